// ===== hdl/canny_nms_double_threshold_defines.svh =====
// ----------------------------------------------------------------------------
// canny_nms_double_threshold assertion macros
// shared property wrappers for the edge classifier checks
// ----------------------------------------------------------------------------
`ifndef CANNY_NMS_DOUBLE_THRESHOLD_DEFINES_SVH
`define CANNY_NMS_DOUBLE_THRESHOLD_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CNMS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("cnms assertion failed");

// next-cycle implication, disabled during reset
`define CNMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("cnms assertion failed");

`endif

// ===== hdl/cnms_pkg.sv =====
// ----------------------------------------------------------------------------
// cnms_pkg
// types and constants shared by the non-maximum suppression block
// ----------------------------------------------------------------------------
`default_nettype none

package cnms_pkg;

	localparam int THR_W     = 24;
	localparam int BW_W      = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [BW_W-1:0] BORDER_RESET = 4'd7;

	// tan(22.5 deg) and tan(67.5 deg) in q16
	localparam int SLOPE_LO_Q16 = 27145;
	localparam int SLOPE_HI_Q16 = 158217;

	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BORDER   = 2'd2;

	typedef enum logic [1:0] {
		SEC_HORZ,
		SEC_DIAG_DOWN,
		SEC_DIAG_UP,
		SEC_VERT
	} sector_t;

	typedef enum logic [1:0] {
		CLASS_NONE,
		CLASS_WEAK,
		CLASS_STRONG
	} edge_class_t;

endpackage

`default_nettype wire

// ===== hdl/cnms_ram.sv =====
// ----------------------------------------------------------------------------
// cnms_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module cnms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/cnms_grad.sv =====
// ----------------------------------------------------------------------------
// cnms_grad
// squared gradient magnitude and quantized direction sector
// ----------------------------------------------------------------------------
`default_nettype none

module cnms_grad
	import cnms_pkg::*;
#(
	parameter int GRAD_BITS = 12
) (
	input  wire logic signed [GRAD_BITS-1:0]   grad_x,
	input  wire logic signed [GRAD_BITS-1:0]   grad_y,
	output logic             [2*GRAD_BITS-1:0] mag,
	output sector_t                            sector
);

	localparam int MAG_W = 2 * GRAD_BITS;
	localparam int PW    = GRAD_BITS + 19;

	localparam logic signed [PW-1:0] LO_S = PW'(SLOPE_LO_Q16);
	localparam logic signed [PW-1:0] HI_S = PW'(SLOPE_HI_Q16);

	logic signed [MAG_W-1:0] sq_x;
	logic signed [MAG_W-1:0] sq_y;
	logic signed [PW-1:0]    gx_e;
	logic signed [PW-1:0]    lhs;
	logic signed [PW-1:0]    p_lo;
	logic signed [PW-1:0]    p_hi;
	logic                    gx_zero;
	logic                    gx_neg;
	logic                    le_lo;
	logic                    le_hi;
	logic                    le_nlo;
	logic                    le_nhi;

	// slope gy/gx <= t, a zero gx acting as a tiny positive value
	function automatic logic slope_le(
		input logic signed [PW-1:0] rhs,
		input logic                 t_nonneg,
		input logic signed [PW-1:0] l,
		input logic                 zero,
		input logic                 neg,
		input logic                 gy_neg,
		input logic                 gy_zero
	);
		logic r;
		if (zero) begin
			r = gy_neg || (gy_zero && t_nonneg);
		end else if (neg) begin
			r = l >= rhs;
		end else begin
			r = l <= rhs;
		end
		return r;
	endfunction

	assign sq_x = grad_x * grad_x;
	assign sq_y = grad_y * grad_y;
	assign mag  = $unsigned(sq_x) + $unsigned(sq_y);

	assign gx_e    = PW'(grad_x);
	assign lhs     = {{3{grad_y[GRAD_BITS-1]}}, grad_y, 16'b0};
	assign p_lo    = gx_e * LO_S;
	assign p_hi    = gx_e * HI_S;
	assign gx_zero = (grad_x == '0);
	assign gx_neg  = grad_x[GRAD_BITS-1];

	always_comb begin
		le_lo  = slope_le(p_lo, 1'b1, lhs, gx_zero, gx_neg, grad_y[GRAD_BITS-1],
			grad_y == '0);
		le_hi  = slope_le(p_hi, 1'b1, lhs, gx_zero, gx_neg, grad_y[GRAD_BITS-1],
			grad_y == '0);
		le_nlo = slope_le(-p_lo, 1'b0, lhs, gx_zero, gx_neg, grad_y[GRAD_BITS-1],
			grad_y == '0);
		le_nhi = slope_le(-p_hi, 1'b0, lhs, gx_zero, gx_neg, grad_y[GRAD_BITS-1],
			grad_y == '0);
		if (le_lo && !le_nlo) begin
			sector = SEC_HORZ;
		end else if (le_hi && !le_lo) begin
			sector = SEC_DIAG_DOWN;
		end else if (le_nlo && !le_nhi) begin
			sector = SEC_DIAG_UP;
		end else begin
			sector = SEC_VERT;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/canny_nms_double_threshold.sv =====
// ----------------------------------------------------------------------------
// canny_nms_double_threshold
// canny non-maximum suppression with double thresholding on a pixel stream
// ----------------------------------------------------------------------------
// Usage: gradient pairs enter in raster order on the input channel
// (in_valid / in_stall), frame_start marking row 0 column 0. One result
// word leaves on the output channel (out_valid / out_stall) per input word,
// classing the pixel one row and one column back: none, weak or strong.
// pixel_valid is low while the first row plus one pixel fill the line store.
// Registers (thresholds, border width) are written over cfg_valid/cfg_ready
// by the user only while the stream is idle; the block does not check it.
// cfg_ready is always high. Throughput is one word per cycle while the
// output is not stalled, set by the line store ram, which takes one read
// and one write per cycle. out_valid rises once a word has gone from the
// input register (whose load starts the ram read) into the result register.
// A stalled output holds its word; the input stalls only when the result
// register is full and stalled and the stage before it is full.
// Reset clears counters, pipeline valids and thresholds, sets border width 7;
// the line store needs no clearing since border pixels never look at it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "canny_nms_double_threshold_defines.svh"

module canny_nms_double_threshold
	import cnms_pkg::*;
#(
	parameter int IMAGE_WIDTH  = 256,
	parameter int IMAGE_HEIGHT = 256,
	parameter int GRAD_BITS    = 12
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [THR_W-1:0]            cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic signed [GRAD_BITS-1:0] grad_x,
	input  wire logic signed [GRAD_BITS-1:0] grad_y,
	input  wire logic                        frame_start,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [1:0]                       edge_class,
	output logic                             pixel_valid
);

	localparam int MAG_W = 2 * GRAD_BITS;
	localparam int COL_W = $clog2(IMAGE_WIDTH);
	localparam int ROW_W = $clog2(IMAGE_HEIGHT);
	localparam int LB_W  = 2 * MAG_W + 2;
	localparam int CX    = COL_W + 5;
	localparam int RX    = ROW_W + 5;
	localparam int CW    = (MAG_W > THR_W) ? MAG_W : THR_W;

	localparam logic [COL_W-1:0] COL_LAST = COL_W'(IMAGE_WIDTH - 1);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(IMAGE_HEIGHT - 1);

	// registers
	logic [THR_W-1:0] high_thr_q;
	logic [THR_W-1:0] low_thr_q;
	logic [BW_W-1:0]  border_q;

	// counters
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] c_in;
	logic [ROW_W-1:0] r_in;

	// handshake
	logic accept;
	logic out_free;
	logic s1_adv;

	// stage 1
	logic             s1_valid_q;
	logic [MAG_W-1:0] mag_s1;
	sector_t          sec_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic             fwd_s1;
	logic [LB_W-1:0]  fwd_data_s1;

	logic [MAG_W-1:0] mag_in;
	sector_t          sec_in;

	// line store
	logic [LB_W-1:0]  lb_rd;
	logic [LB_W-1:0]  lb_word;
	logic [LB_W-1:0]  lb_wr;
	logic [MAG_W-1:0] up_s1;
	logic [MAG_W-1:0] ce_s1;
	sector_t          old_sec_s1;

	// window: columns 0 and 1 of the 3x3 window
	logic [MAG_W-1:0] win_q [3][2];
	sector_t          dsec_q;

	// decision
	logic             pix_ok;
	logic [ROW_W-1:0] dr;
	logic [COL_W-1:0] dc;
	logic [BW_W-1:0]  bw;
	logic             inside_img;
	logic [MAG_W-1:0] centre;
	logic [MAG_W-1:0] nb_a;
	logic [MAG_W-1:0] nb_b;
	logic             peak;
	edge_class_t      cls;

	// output register
	logic        out_valid_q;
	edge_class_t cls_q;
	logic        pix_ok_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_thr_q <= '0;
			low_thr_q  <= '0;
			border_q   <= BORDER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HIGH_THR: high_thr_q <= cfg_data;
				CFG_LOW_THR:  low_thr_q  <= cfg_data;
				CFG_BORDER:   border_q   <= cfg_data[BW_W-1:0];
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign s1_adv   = s1_valid_q && out_free;
	assign in_stall = s1_valid_q && !out_free;
	assign accept   = in_valid && !in_stall;

	assign c_in = frame_start ? '0 : col_q;
	assign r_in = frame_start ? '0 : row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (c_in == COL_LAST) begin
				col_q <= '0;
				row_q <= (r_in == ROW_LAST) ? '0 : r_in + 1'b1;
			end else begin
				col_q <= c_in + 1'b1;
				row_q <= r_in;
			end
		end
	end

	cnms_grad #(
		.GRAD_BITS(GRAD_BITS)
	) u_grad (
		.grad_x(grad_x),
		.grad_y(grad_y),
		.mag   (mag_in),
		.sector(sec_in)
	);

	// row shift: upper takes the old centre, centre takes the new magnitude
	assign lb_wr = {ce_s1, mag_s1, sec_s1};

	cnms_ram #(
		.WIDTH(LB_W),
		.DEPTH(IMAGE_WIDTH)
	) u_line (
		.clk    (clk),
		.wr_en  (s1_adv),
		.wr_addr(col_s1),
		.wr_data(lb_wr),
		.rd_en  (accept),
		.rd_addr(c_in),
		.rd_data(lb_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_s1      <= mag_in;
			sec_s1      <= sec_in;
			col_s1      <= c_in;
			row_s1      <= r_in;
			// same column written this cycle by the word ahead
			fwd_s1      <= s1_adv && (col_s1 == c_in);
			fwd_data_s1 <= lb_wr;
		end
	end

	assign lb_word    = fwd_s1 ? fwd_data_s1 : lb_rd;
	assign up_s1      = lb_word[LB_W-1 -: MAG_W];
	assign ce_s1      = lb_word[MAG_W+1 -: MAG_W];
	assign old_sec_s1 = sector_t'(lb_word[1:0]);

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k][0] <= win_q[k][1];
			end
			win_q[0][1] <= up_s1;
			win_q[1][1] <= ce_s1;
			win_q[2][1] <= mag_s1;
			dsec_q      <= old_sec_s1;
		end
	end

	// column 0 delayed pixel is last column of previous row, always border
	always_comb begin
		pix_ok = (row_s1 >= ROW_W'(2)) || (row_s1 == ROW_W'(1) && col_s1 != '0);
		dr     = row_s1 - 1'b1;
		dc     = col_s1 - 1'b1;
		bw     = (border_q == '0) ? BW_W'(1) : border_q;
		inside_img = pix_ok && (col_s1 != '0)
			&& (RX'(dr) >= RX'(bw)) && (RX'(dr) + RX'(bw) < RX'(IMAGE_HEIGHT))
			&& (CX'(dc) >= CX'(bw)) && (CX'(dc) + CX'(bw) < CX'(IMAGE_WIDTH));
	end

	// neighbours from the shifted window: col 0 = win_q[][0], col 1 = win_q[][1]
	always_comb begin
		centre = win_q[1][1];
		case (dsec_q)
			SEC_HORZ: begin
				nb_a = win_q[1][0];
				nb_b = ce_s1;
			end
			SEC_DIAG_DOWN: begin
				nb_a = win_q[0][0];
				nb_b = mag_s1;
			end
			SEC_DIAG_UP: begin
				nb_a = win_q[2][0];
				nb_b = up_s1;
			end
			default: begin
				nb_a = win_q[0][1];
				nb_b = win_q[2][1];
			end
		endcase
		peak = (centre > nb_a) && (centre > nb_b);
		if (!inside_img || !peak) begin
			cls = CLASS_NONE;
		end else if (CW'(centre) > CW'(high_thr_q)) begin
			cls = CLASS_STRONG;
		end else if (CW'(centre) < CW'(low_thr_q)) begin
			cls = CLASS_NONE;
		end else begin
			cls = CLASS_WEAK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			cls_q    <= cls;
			pix_ok_q <= pix_ok;
		end
	end

	assign out_valid   = out_valid_q;
	assign edge_class  = cls_q;
	assign pixel_valid = pix_ok_q;

	`CNMS_ASSERT_NOW(a_class_needs_valid, clk, arst_n, out_valid && !pixel_valid,
		edge_class == CLASS_NONE)
	`CNMS_ASSERT_NOW(a_class_legal, clk, arst_n, out_valid,
		edge_class == CLASS_NONE || edge_class == CLASS_WEAK || edge_class == CLASS_STRONG)
	`CNMS_ASSERT_NOW(a_stall_cause, clk, arst_n, in_stall,
		out_valid && out_stall && s1_valid_q)
	`CNMS_ASSERT_NEXT(a_stage_moves, clk, arst_n, s1_adv, out_valid)

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// canny_nms_double_threshold testbench
// streams gradient frames through the block, predicts every result word from
// a cycle-free model of the line store and window, and checks each word
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import cnms_pkg::*;

	localparam int IMG_W = 256;
	localparam int IMG_H = 256;
	localparam int GRAD_W = 12;
	localparam longint TAN22_Q16 = 27145;
	localparam longint TAN67_Q16 = 158217;
	localparam int MAX_THR = 8388608;
	localparam int BORDER_AFTER_RESET = 7;
	localparam int HOLD_CYCLES = 120;
	localparam int NCORNER = 24;

	typedef struct packed {
		edge_class_t cls;
		logic        live;
	} class_word_t;

	class nms_scoreboard;
		logic [THR_W-1:0] high_thr;
		logic [THR_W-1:0] low_thr;
		logic [BW_W-1:0]  border;
		logic [THR_W-1:0] mag_upper [IMG_W];
		logic [THR_W-1:0] mag_centre [IMG_W];
		sector_t          sector_line [IMG_W];
		logic [THR_W-1:0] win [3][3];
		int unsigned      col;
		int unsigned      row;
		sector_t          held_sector;
		class_word_t      expected_q [$];
		int unsigned      checked;
		int unsigned      mismatches;

		function new();
			high_thr = '0;
			low_thr = '0;
			border = BW_W'(BORDER_AFTER_RESET);
			foreach (mag_upper[i]) begin
				mag_upper[i] = '0;
				mag_centre[i] = '0;
				sector_line[i] = SEC_HORZ;
			end
			foreach (win[i, j]) win[i][j] = '0;
			col = 0;
			row = 0;
			held_sector = SEC_HORZ;
			checked = 0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] data);
			case (idx)
				CFG_HIGH_THR: high_thr = data;
				CFG_LOW_THR:  low_thr = data;
				CFG_BORDER:   border = data[BW_W-1:0];
				default: ;
			endcase
		endfunction

		// gy/gx <= t/65536, a zero gx counts as a tiny positive value
		function bit slope_at_most(longint gx, longint gy, longint t);
			if (gx == 0) return (gy < 0) || (gy == 0 && t >= 0);
			if (gx > 0) return gy * 65536 <= t * gx;
			return gy * 65536 >= t * gx;
		endfunction

		function sector_t sector_of_grad(longint gx, longint gy);
			bit lo, hi, nlo, nhi;
			lo = slope_at_most(gx, gy, TAN22_Q16);
			hi = slope_at_most(gx, gy, TAN67_Q16);
			nlo = slope_at_most(gx, gy, -TAN22_Q16);
			nhi = slope_at_most(gx, gy, -TAN67_Q16);
			if (lo && !nlo) return SEC_HORZ;
			if (hi && !lo) return SEC_DIAG_DOWN;
			if (nlo && !nhi) return SEC_DIAG_UP;
			return SEC_VERT;
		endfunction

		function void note_pixel(logic signed [GRAD_W-1:0] gx, logic signed [GRAD_W-1:0] gy,
				logic fs);
			longint sx, sy;
			int unsigned r, c, dr, dc, bw;
			logic [THR_W-1:0] mag, centre;
			sector_t sec, csec;
			bit live, peak;
			edge_class_t cls;
			class_word_t w;
			sx = gx;
			sy = gy;
			if (fs) begin
				col = 0;
				row = 0;
			end
			r = row;
			c = col;
			mag = THR_W'(sx * sx + sy * sy);
			sec = sector_of_grad(sx, sy);
			for (int k = 0; k < 3; k++) begin
				win[k][0] = win[k][1];
				win[k][1] = win[k][2];
			end
			win[0][2] = mag_upper[c];
			win[1][2] = mag_centre[c];
			win[2][2] = mag;
			// sector of the pixel one row up and one column left
			csec = held_sector;
			held_sector = sector_line[c];
			mag_upper[c] = mag_centre[c];
			mag_centre[c] = mag;
			sector_line[c] = sec;

			live = (r >= 2) || (r == 1 && c >= 1);
			if (c >= 1) begin
				dr = r - 1;
				dc = c - 1;
			end else begin
				dr = r - 2;
				dc = IMG_W - 1;
			end
			bw = (border != 0) ? border : 1;
			cls = CLASS_NONE;
			peak = 1'b0;
			if (live && dr >= bw && dr + bw < IMG_H && dc >= bw && dc + bw < IMG_W) begin
				centre = win[1][1];
				case (csec)
					SEC_HORZ:      peak = centre > win[1][0] && centre > win[1][2];
					SEC_DIAG_DOWN: peak = centre > win[0][0] && centre > win[2][2];
					SEC_DIAG_UP:   peak = centre > win[2][0] && centre > win[0][2];
					default:       peak = centre > win[0][1] && centre > win[2][1];
				endcase
				if (peak) begin
					if (centre > high_thr) cls = CLASS_STRONG;
					else if (centre < low_thr) cls = CLASS_NONE;
					else cls = CLASS_WEAK;
				end
			end

			col = c + 1;
			if (col >= IMG_W) begin
				col = 0;
				row = r + 1;
				if (row >= IMG_H) row = 0;
			end
			w.cls = cls;
			w.live = live;
			expected_q.push_back(w);
		endfunction

		function void report_field(string field, logic [1:0] exp, logic [1:0] act);
			mismatches++;
			if (mismatches <= 10)
				$display("word %0d: %s expected %0d, got %0d", checked, field, exp, act);
		endfunction

		function void check_word(logic [1:0] cls, logic live);
			class_word_t w;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("word %0d: unexpected, edge_class %0d pixel_valid %0d",
						checked, cls, live);
				return;
			end
			w = expected_q.pop_front();
			if (cls !== w.cls) report_field("edge_class", w.cls, cls);
			if (live !== w.live) report_field("pixel_valid", w.live, live);
			checked++;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function int unsigned failures();
			return mismatches + expected_q.size();
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [THR_W-1:0]         cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic signed [GRAD_W-1:0] grad_x = '0;
	logic signed [GRAD_W-1:0] grad_y = '0;
	logic                     frame_start = 1'b0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [1:0]               edge_class;
	logic                     pixel_valid;

	nms_scoreboard sb;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int unsigned hold_requests = 0;
	int unsigned holds_served = 0;
	int unsigned hold_left = 0;

	// sector boundaries, zero gx and field extremes
	int corner_gx [NCORNER] = '{0, 0, 0, 5, -5, 2047, -2048, 2047, -2048, 2047, 2047, 2047,
		2047, -2047, -2047, 848, 847, -848, -847, 0, 0, -2048, -1, 1};
	int corner_gy [NCORNER] = '{0, 5, -5, 0, 0, 2047, -2048, -2048, 2047, 847, 848, -847,
		-848, 847, 848, 2047, 2047, 2047, 2047, -2048, 2047, 0, -1, -1};

	canny_nms_double_threshold #(
		.IMAGE_WIDTH (IMG_W),
		.IMAGE_HEIGHT(IMG_H),
		.GRAD_BITS   (GRAD_W)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.grad_x     (grad_x),
		.grad_y     (grad_y),
		.frame_start(frame_start),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.edge_class (edge_class),
		.pixel_valid(pixel_valid)
	);

	always #2 clk = ~clk;

	// receiver: random stalls, or a long hold-off when one is requested
	always @(negedge clk) begin
		if (holds_served != hold_requests) begin
			holds_served++;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall = 1'b1;
		end else begin
			out_stall = ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_word(edge_class, pixel_valid);
	end

	function automatic void draw_gradient(output logic signed [GRAD_W-1:0] gx,
			output logic signed [GRAD_W-1:0] gy);
		int k;
		case ($urandom_range(9))
			0, 1, 2: begin
				gx = GRAD_W'($urandom);
				gy = GRAD_W'($urandom);
			end
			// small values make ties between neighbours and thresholds likely
			3, 4, 5: begin
				gx = GRAD_W'($urandom_range(6) - 3);
				gy = GRAD_W'($urandom_range(6) - 3);
			end
			6: begin
				k = $urandom_range(NCORNER - 1);
				gx = GRAD_W'(corner_gx[k]);
				gy = GRAD_W'(corner_gy[k]);
			end
			7: begin
				gx = '0;
				gy = GRAD_W'($urandom);
			end
			8: begin
				gx = GRAD_W'($urandom);
				gy = '0;
			end
			default: begin
				gx = GRAD_W'($urandom_range(64) - 32);
				gy = GRAD_W'($urandom_range(64) - 32);
			end
		endcase
	endfunction

	function automatic logic [THR_W-1:0] pick_thr();
		case ($urandom_range(2))
			0: return THR_W'($urandom_range(MAX_THR));
			1: return THR_W'($urandom_range(40));
			default: return $urandom_range(1) ? THR_W'(MAX_THR) : '0;
		endcase
	endfunction

	task automatic offer_gradient(input logic signed [GRAD_W-1:0] gx,
			input logic signed [GRAD_W-1:0] gy, input logic fs);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		grad_x = gx;
		grad_y = gy;
		frame_start = fs;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_pixel(gx, gy, fs);
	endtask

	task automatic wait_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic apply_config(input logic [THR_W-1:0] high, input logic [THR_W-1:0] low,
			input logic [BW_W-1:0] bw);
		wait_results();
		// idle clocks between the drained pipeline and the register writes
		repeat (4) @(posedge clk);
		write_reg(CFG_HIGH_THR, high);
		write_reg(CFG_LOW_THR, low);
		write_reg(CFG_BORDER, THR_W'(bw));
	endtask

	task automatic stream_frame(input int len, input bit fresh, input bit stray);
		int hold_at, drain_at;
		logic signed [GRAD_W-1:0] gx, gy;
		logic fs;
		hold_at = $urandom_range(len - 1);
		drain_at = $urandom_range(len - 1);
		for (int i = 0; i < len; i++) begin
			if (i == hold_at) hold_requests++;
			if (i == drain_at) wait_results();
			draw_gradient(gx, gy);
			fs = (fresh && i == 0) || (stray && $urandom_range(399) == 0);
			offer_gradient(gx, gy, fs);
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 26;
		stall_pct = 49;
		for (int k = 0; k < NCORNER; k++)
			offer_gradient(GRAD_W'(corner_gx[k]), GRAD_W'(corner_gy[k]), k == 0);
		apply_config(pick_thr(), pick_thr(), BW_W'(1));
		// run on into row two, where the first interior pixels are decided
		stream_frame($urandom_range(480, 510), 0, 0);
		// zero border width behaves as one
		apply_config('0, '0, '0);
		stream_frame($urandom_range(60, 80), 0, 0);

		send_idle_pct = 49;
		stall_pct = 26;
		// crossed thresholds, high test wins
		apply_config(THR_W'($urandom_range(20)), THR_W'($urandom_range(1000, MAX_THR)),
			BW_W'(1));
		stream_frame($urandom_range(60, 80), 0, 0);

		send_idle_pct = 0;
		stall_pct = 0;
		apply_config(pick_thr(), pick_thr(), BW_W'(1));
		stream_frame($urandom_range(60, 80), 0, 0);
		// new frames back to back, frame_start on neighbouring words
		stream_frame($urandom_range(1, 3), 1, 0);
		stream_frame($urandom_range(1, 3), 1, 0);
		stream_frame($urandom_range(20, 40), 1, 1);

		wait_results();
		repeat (8) @(posedge clk);
		if (sb.failures() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/cnms_pkg.sv
hdl/cnms_ram.sv
hdl/cnms_grad.sv
hdl/canny_nms_double_threshold.sv
verif/testbench.sv
